### rtl/clft_pkg.sv
package clft_pkg;

    // Table geometry default
    localparam int SLOTS_DEF = 16;

    // Field widths
    localparam int ID_W     = 11;
    localparam int DLC_W    = 4;
    localparam int DATA_W   = 64;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int USED_W   = 5;

    // Stored word: {rtr, dlc, data}
    localparam int ENTRY_W  = DATA_W + DLC_W + 1;

    // Stream packing
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 80;

    // Operation codes
    localparam logic [OP_W-1:0] OP_STORE  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Store status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_UPDATED  = 3'd0,
        STS_NEW      = 3'd1,
        STS_EXTENDED = 3'd2,
        STS_FULL     = 3'd3,
        STS_NONE     = 3'd4
    } t_status;

    // Control sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // Directory update request
    typedef struct packed {
        logic alloc;
        logic clear_all;
    } t_dir_cmd;

    // Directory search result
    typedef struct packed {
        logic hit;
        logic free;
    } t_dir_stat;

endpackage

### rtl/clft_ram.sv
module clft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/clft_dir.sv
module clft_dir #(
    parameter int SLOTS = clft_pkg::SLOTS_DEF,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [clft_pkg::ID_W-1:0]    i_id,
    input  clft_pkg::t_dir_cmd           i_cmd,
    output clft_pkg::t_dir_stat          o_stat,
    output logic [IW-1:0]                o_hit_idx,
    output logic [IW-1:0]                o_free_idx,
    output logic [CW-1:0]                o_count_next
);

    logic [SLOTS-1:0]              r_valid;
    logic [clft_pkg::ID_W-1:0]     r_id [SLOTS];
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;

    logic [SLOTS-1:0]              match;
    logic [IW-1:0]                 hit_idx;
    logic [IW-1:0]                 free_idx;

    // Per-slot identifier compare
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match[i] = r_valid[i] && (r_id[i] == i_id);
        end
    end

    // Lowest matching slot and lowest free slot
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    assign o_stat.hit  = |match;
    assign o_stat.free = ~&r_valid;
    assign o_hit_idx   = hit_idx;
    assign o_free_idx  = free_idx;

    // Occupancy count
    always_comb begin
        n_count = r_count;
        if (i_cmd.clear_all) begin
            n_count = '0;
        end else if (i_cmd.alloc) begin
            n_count = r_count + CW'(1);
        end
    end

    assign o_count_next = n_count;

    // Valid bits and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.clear_all) begin
                r_valid <= '0;
            end else if (i_cmd.alloc) begin
                r_valid[free_idx] <= 1'b1;
            end
        end
    end

    // Identifier tags, written on allocation
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_id[free_idx] <= i_id;
        end
    end

endmodule

### rtl/can_latest_frame_by_id_table_top.sv
// Latest-frame table for standard-identifier CAN frames.
// Input stream (s_axis): one transaction per command. tuser carries the
// operation (store, lookup, clear); tdata carries identifier, extended
// flag, length code, remote flag and payload. Output stream (m_axis): one
// transaction per command with store status, lookup result and the slot
// count after the command.
// Store, clear and unused codes complete in the accept cycle: the identifier
// compare runs over the tag flops in the accept cycle and the payload RAM is
// written at the same edge. A lookup passes through the payload RAM read
// register and then the read state; the input is not ready during the read cycle.
// Results sit in an output register; a new command is taken in the same
// cycle as the previous result is consumed. While the receiver stalls with
// a result pending, s_axis_tready stays low and nothing is lost.
// Reset (synchronous, active low) invalidates every slot and zeroes the
// count at once; payload and tag storage need no clearing pass.
module can_latest_frame_by_id_table_top #(
    parameter int SLOTS = clft_pkg::SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [10:0] frame_id, [11] is_extended, [15:12] frame_dlc, [16] frame_rtr,
    // [80:17] frame_data, [87:81] zero
    input  logic [clft_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] operation
    input  logic [clft_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [2:0] store_status, [3] found, [7:4] result_dlc, [8] result_rtr,
    // [72:9] result_data, [77:73] entries_used, [79:78] zero
    output logic [clft_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    // Input field unpack
    logic [clft_pkg::OP_W-1:0]   in_op;
    logic [clft_pkg::ID_W-1:0]   in_id;
    logic                        in_ext;
    logic [clft_pkg::DLC_W-1:0]  in_dlc;
    logic                        in_rtr;
    logic [clft_pkg::DATA_W-1:0] in_data;

    assign in_op   = s_axis_tuser;
    assign in_id   = s_axis_tdata[10:0];
    assign in_ext  = s_axis_tdata[11];
    assign in_dlc  = s_axis_tdata[15:12];
    assign in_rtr  = s_axis_tdata[16];
    assign in_data = s_axis_tdata[80:17];

    // Directory
    clft_pkg::t_dir_cmd   dir_cmd;
    clft_pkg::t_dir_stat  dir_stat;
    logic [IW-1:0]        hit_idx;
    logic [IW-1:0]        free_idx;
    logic [CW-1:0]        count_next;

    clft_dir #(
        .SLOTS (SLOTS)
    ) u_dir (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_id         (in_id),
        .i_cmd        (dir_cmd),
        .o_stat       (dir_stat),
        .o_hit_idx    (hit_idx),
        .o_free_idx   (free_idx),
        .o_count_next (count_next)
    );

    // Payload RAM
    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    logic                          ram_re;
    logic [clft_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [clft_pkg::ENTRY_W-1:0]  ram_rdata;

    assign ram_wdata = {in_rtr, in_dlc, in_data};

    clft_ram #(
        .WIDTH (clft_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (hit_idx),
        .o_rdata (ram_rdata)
    );

    // Control and output registers
    clft_pkg::t_state              r_state, n_state;
    logic                          r_lk_hit, n_lk_hit;
    logic                          r_out_valid, n_out_valid;
    clft_pkg::t_status             r_status, n_status;
    logic                          r_found, n_found;
    logic [clft_pkg::DLC_W-1:0]    r_dlc, n_dlc;
    logic                          r_rtr, n_rtr;
    logic [clft_pkg::DATA_W-1:0]   r_data, n_data;
    logic [clft_pkg::USED_W-1:0]   r_used, n_used;

    logic accept;

    assign s_axis_tready = (r_state == clft_pkg::ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Sequencer: command decode, table update, result load
    always_comb begin
        n_state     = r_state;
        n_lk_hit    = r_lk_hit;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_status    = r_status;
        n_found     = r_found;
        n_dlc       = r_dlc;
        n_rtr       = r_rtr;
        n_data      = r_data;
        n_used      = r_used;
        dir_cmd     = '0;
        ram_we      = 1'b0;
        ram_waddr   = hit_idx;
        ram_re      = 1'b0;

        case (r_state)
            clft_pkg::ST_IDLE: begin
                if (accept) begin
                    n_found  = 1'b0;
                    n_dlc    = '0;
                    n_rtr    = 1'b0;
                    n_data   = '0;
                    n_status = clft_pkg::STS_NONE;
                    case (in_op)
                        clft_pkg::OP_STORE: begin
                            if (in_ext) begin
                                n_status = clft_pkg::STS_EXTENDED;
                            end else if (dir_stat.hit) begin
                                n_status = clft_pkg::STS_UPDATED;
                                ram_we   = 1'b1;
                            end else if (dir_stat.free) begin
                                n_status      = clft_pkg::STS_NEW;
                                dir_cmd.alloc = 1'b1;
                                ram_we        = 1'b1;
                                ram_waddr     = free_idx;
                            end else begin
                                n_status = clft_pkg::STS_FULL;
                            end
                        end
                        clft_pkg::OP_LOOKUP: begin
                            ram_re   = 1'b1;
                            n_lk_hit = dir_stat.hit;
                        end
                        clft_pkg::OP_CLEAR: begin
                            dir_cmd.clear_all = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    n_used = clft_pkg::USED_W'(count_next);
                    if (in_op == clft_pkg::OP_LOOKUP) begin
                        n_state = clft_pkg::ST_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            clft_pkg::ST_READ: begin
                // Output register is free here: it was empty or drained at accept
                n_out_valid = 1'b1;
                n_found     = r_lk_hit;
                if (r_lk_hit) begin
                    n_rtr  = ram_rdata[clft_pkg::ENTRY_W-1];
                    n_dlc  = ram_rdata[clft_pkg::ENTRY_W-2 -: clft_pkg::DLC_W];
                    n_data = ram_rdata[clft_pkg::DATA_W-1:0];
                end
                n_state = clft_pkg::ST_IDLE;
            end
            default: begin
                n_state = clft_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clft_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_lk_hit <= n_lk_hit;
        r_status <= n_status;
        r_found  <= n_found;
        r_dlc    <= n_dlc;
        r_rtr    <= n_rtr;
        r_data   <= n_data;
        r_used   <= n_used;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_used, r_data, r_rtr, r_dlc, r_found, r_status};

endmodule
